FILE: design/assert_macros.svh
// Assertion macros shared by the vertex normal accumulator modules.
// No dependencies; the checks drop out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

FILE: design/vna_pkg.sv
// Shared types and constants for the vertex normal accumulator.
// No dependencies.
package vna_pkg;

    localparam int IDX_BITS = 10;
    localparam int CRD_BITS = 24;
    localparam int NRM_BITS = 16;
    localparam int UNIT     = 16384;

    typedef enum logic [2:0] {
        OP_WRITE = 3'd0,
        OP_TRI   = 3'd1,
        OP_QUAD  = 3'd2,
        OP_CLEAR = 3'd3,
        OP_READ  = 3'd4
    } op_t;

    typedef struct packed {
        logic [2:0]                  operation;
        logic [IDX_BITS-1:0]         index_a;
        logic [IDX_BITS-1:0]         index_b;
        logic [IDX_BITS-1:0]         index_c;
        logic [IDX_BITS-1:0]         index_d;
        logic signed [CRD_BITS-1:0]  pos_x;
        logic signed [CRD_BITS-1:0]  pos_y;
        logic signed [CRD_BITS-1:0]  pos_z;
    } item_in_t;

    typedef struct packed {
        logic [IDX_BITS-1:0]         vertex_index;
        logic signed [NRM_BITS-1:0]  normal_x;
        logic signed [NRM_BITS-1:0]  normal_y;
        logic signed [NRM_BITS-1:0]  normal_z;
        logic                        is_zero;
    } item_out_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CLEAR,
        S_LOAD,
        S_LOAD_WAIT,
        S_EDGE,
        S_CROSS,
        S_CROSS2,
        S_NORM_START,
        S_NORM_WAIT,
        S_ACC_RD,
        S_ACC_WAIT,
        S_ACC_WR,
        S_READ_RD,
        S_READ_WAIT,
        S_READ_NORM,
        S_READ_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       pos_write;
        logic       clear_step;
        logic       pos_read;
        logic [1:0] corner_sel;
        logic       edge_calc;
        logic       cross_calc;
        logic       cross_sub;
        logic       norm_start;
        logic       sum_read;
        logic       sum_write;
        logic       result_from_read;
        logic       read_norm_start;
        logic       emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done;
        logic norm_done;
        logic norm_zero;
    } status_t;

endpackage

FILE: design/vertex_normal_accumulator_core.sv
// Top level of the vertex normal accumulator: controller plus datapath.
// Depends on vna_pkg, vna_ctrl and vna_dpath.
//
//   channel   signals                 accepted when
//   input     start, busy, item_in    start high, busy low
//   result    strobe, item_out        strobe high (one cycle)
//
// A write leaves busy low; a clear keeps busy high while it zeroes all MAX_VERTICES sum entries.
// A face keeps busy high through the corner loads, edge and cross product, the scaler (shifts,
// 32-step root, three divides) and the corner updates, which a zero cross product skips.
// A read keeps busy high through the sum read and the scaler; strobe follows in the next cycle.
// After reset a clearing pass over all MAX_VERTICES entries runs with busy high.
// The receiver cannot stall; one item is in work at a time.
module vertex_normal_accumulator_core #(
    parameter int MAX_VERTICES = 1024,
    parameter int SUM_BITS     = 20
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  vna_pkg::item_in_t  item_in,
    output logic               strobe,
    output vna_pkg::item_out_t item_out
);
    import vna_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    take;

    assign take = start && !busy;

    vna_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (take),
        .operation (item_in.operation),
        .busy      (busy),
        .cmd       (cmd),
        .status    (status)
    );

    vna_dpath #(
        .MAX_VERTICES (MAX_VERTICES),
        .SUM_BITS     (SUM_BITS)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .item_in  (item_in),
        .take     (take),
        .cmd      (cmd),
        .status   (status),
        .strobe   (strobe),
        .item_out (item_out)
    );

endmodule

FILE: design/vna_unit.sv
// Iterative unit-vector scaler: normalize, integer square root, three divisions.
// Depends on vna_pkg. One dependent step per cycle.
module vna_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [63:0]                vx,
    input  logic signed [63:0]                vy,
    input  logic signed [63:0]                vz,
    output logic                              done,
    output logic                              zero,
    output logic signed [vna_pkg::NRM_BITS-1:0] ux,
    output logic signed [vna_pkg::NRM_BITS-1:0] uy,
    output logic signed [vna_pkg::NRM_BITS-1:0] uz
);
    import vna_pkg::*;

    typedef enum logic [3:0] {
        U_IDLE, U_SHIFT, U_SQ0, U_SQ1, U_SQ2, U_SQRT, U_DIV, U_DONE
    } ustate_t;

    ustate_t     state_reg, state_next;
    logic [62:0] mag_reg [3];
    logic [2:0]  neg_reg;
    logic [63:0] q_reg;
    logic [31:0] root_reg;
    logic [63:0] rem_reg;
    logic [5:0]  cnt_reg;
    logic [1:0]  comp_reg;
    logic [15:0] quo_reg [3];
    logic        zero_reg;
    logic [62:0] top;
    logic [30:0] m30;
    logic [61:0] sq;
    logic [65:0] trial;
    logic [63:0] qsh;

    always_comb
    begin
        top = mag_reg[0] | mag_reg[1] | mag_reg[2];
        m30 = mag_reg[comp_reg][30:0];
        sq  = 62'(m30) * 62'(m30);
        trial = {rem_reg[63:0], q_reg[63:62]} - {32'd0, root_reg, 2'b01};
        qsh = q_reg << 2;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            U_IDLE:  if (start) state_next = U_SHIFT;
            U_SHIFT: if (top == '0) state_next = U_DONE;
                     else if (top[62:30] == '0 && top[29]) state_next = U_SQ0;
            U_SQ0:   state_next = U_SQ1;
            U_SQ1:   state_next = U_SQ2;
            U_SQ2:   state_next = U_SQRT;
            U_SQRT:  if (cnt_reg == 6'd31) state_next = U_DIV;
            U_DIV:   if (comp_reg == 2'd2 && cnt_reg == 6'd15) state_next = U_DONE;
            U_DONE:  state_next = U_IDLE;
            default: state_next = U_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Magnitudes are shifted one bit a cycle until the largest lies in [2^29, 2^30).
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            U_IDLE:
            begin
                if (start)
                begin
                    mag_reg[0] <= vx[63] ? 63'(-vx) : vx[62:0];
                    mag_reg[1] <= vy[63] ? 63'(-vy) : vy[62:0];
                    mag_reg[2] <= vz[63] ? 63'(-vz) : vz[62:0];
                    neg_reg <= {vz[63], vy[63], vx[63]};
                end
                comp_reg <= 2'd0;
                zero_reg <= 1'b0;
            end
            U_SHIFT:
            begin
                if (top == '0)
                begin
                    zero_reg <= 1'b1;
                    quo_reg[0] <= '0;
                    quo_reg[1] <= '0;
                    quo_reg[2] <= '0;
                end
                else if (top[62:30] != '0)
                begin
                    for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] >> 1;
                end
                else if (!top[29])
                begin
                    for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] << 1;
                end
                q_reg <= '0;
            end
            U_SQ0, U_SQ1, U_SQ2:
            begin
                q_reg <= q_reg + {2'd0, sq};
                comp_reg <= (comp_reg == 2'd2) ? 2'd0 : comp_reg + 2'd1;
                root_reg <= '0;
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            U_SQRT:
            begin
                if (!trial[65])
                begin
                    rem_reg <= trial[63:0];
                    root_reg <= {root_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[61:0], q_reg[63:62]};
                    root_reg <= {root_reg[30:0], 1'b0};
                end
                q_reg <= qsh;
                cnt_reg <= (cnt_reg == 6'd31) ? 6'd0 : cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    comp_reg <= 2'd0;
                end
            end
            U_DIV:
            begin
                // Each component is one load followed by 15 quotient bits.
                cnt_reg <= (cnt_reg == 6'd15) ? 6'd0 : cnt_reg + 6'd1;
                if (cnt_reg == 6'd15)
                    comp_reg <= (comp_reg == 2'd2) ? 2'd0 : comp_reg + 2'd1;
            end
            default:
            begin
            end
        endcase
    end

    // Division datapath: long division of N = mag*16384 + root/2 by root.
    // The quotient fits 15 bits since mag <= root; partial remainder kept in rdiv_reg.
    logic [45:0] num;
    logic [31:0] rdiv_reg;
    logic [32:0] rtrial;
    logic [45:0] nbits_reg;
    always_comb
    begin
        num = 46'({m30, 14'd0}) + 46'(root_reg >> 1);
        rtrial = {rdiv_reg, nbits_reg[45]} - {1'b0, root_reg};
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == U_SQRT && cnt_reg == 6'd31)
        begin
            rdiv_reg <= '0;
            nbits_reg <= '0;
        end
        else if (state_reg == U_DIV)
        begin
            if (cnt_reg == 6'd0)
            begin
                // Load: preshift the top 31 bits straight into the remainder.
                rdiv_reg <= {1'b0, num[45:15]};
                nbits_reg <= {num[14:0], 31'd0};
                quo_reg[comp_reg] <= '0;
            end
            else
            begin
                if (!rtrial[32])
                begin
                    rdiv_reg <= rtrial[31:0];
                    quo_reg[comp_reg] <= {quo_reg[comp_reg][14:0], 1'b1};
                end
                else
                begin
                    rdiv_reg <= {rdiv_reg[30:0], nbits_reg[45]};
                    quo_reg[comp_reg] <= {quo_reg[comp_reg][14:0], 1'b0};
                end
                nbits_reg <= nbits_reg << 1;
            end
        end
    end

    logic [15:0] c [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            c[i] = (quo_reg[i] > 16'(UNIT)) ? 16'(UNIT) : quo_reg[i];
        end
        done = (state_reg == U_DONE);
        zero = zero_reg;
        ux = neg_reg[0] ? -$signed(c[0]) : $signed(c[0]);
        uy = neg_reg[1] ? -$signed(c[1]) : $signed(c[1]);
        uz = neg_reg[2] ? -$signed(c[2]) : $signed(c[2]);
    end

    `include "assert_macros.svh"
    `ASSERT_NEVER(a_start_busy, clk, rst_n, start && state_reg != U_IDLE, "unit restarted busy")
    `ASSERT_IMPL(a_done_one, clk, rst_n, done |=> !done, "done held")
    `ASSERT_IMPL(a_sqrt_len, clk, rst_n, (state_reg == U_SQ2) |=> (state_reg == U_SQRT), "sqrt skip")

endmodule

FILE: design/vna_ctrl.sv
// Controller state machine for the vertex normal accumulator.
// Depends on vna_pkg.
module vna_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [2:0]        operation,
    output logic              busy,
    output vna_pkg::cmd_t     cmd,
    input  vna_pkg::status_t  status
);
    import vna_pkg::*;

    state_t     state_reg, state_next;
    logic       quad_reg, quad_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] last;

    assign last = quad_reg ? 2'd3 : 2'd2;

    always_comb
    begin
        state_next = state_reg;
        quad_next = quad_reg;
        cnt_next = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (start)
                begin
                    quad_next = (operation == OP_QUAD);
                    case (operation)
                        OP_TRI, OP_QUAD: state_next = S_LOAD;
                        OP_CLEAR:        state_next = S_CLEAR;
                        OP_READ:         state_next = S_READ_RD;
                        default:         state_next = S_IDLE;
                    endcase
                end
            end
            S_CLEAR:      if (status.clear_done) state_next = S_IDLE;
            S_LOAD:
            begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == last) state_next = S_LOAD_WAIT;
            end
            S_LOAD_WAIT:  state_next = S_EDGE;
            S_EDGE:       state_next = S_CROSS;
            S_CROSS:      state_next = S_CROSS2;
            S_CROSS2:     state_next = S_NORM_START;
            S_NORM_START: state_next = S_NORM_WAIT;
            S_NORM_WAIT:
            begin
                cnt_next = '0;
                if (status.norm_done)
                    state_next = status.norm_zero ? S_IDLE : S_ACC_RD;
            end
            S_ACC_RD:     state_next = S_ACC_WAIT;
            S_ACC_WAIT:   state_next = S_ACC_WR;
            S_ACC_WR:
            begin
                cnt_next = cnt_reg + 2'd1;
                state_next = (cnt_reg == last) ? S_IDLE : S_ACC_RD;
            end
            S_READ_RD:    state_next = S_READ_WAIT;
            S_READ_WAIT:  state_next = S_READ_NORM;
            S_READ_NORM:  if (status.norm_done) state_next = S_READ_DONE;
            S_READ_DONE:  state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    // The corner select stays on the current corner through the accumulate and read wait states.
    always_comb
    begin
        cmd = '0;
        cmd.corner_sel = cnt_reg;
        unique case (state_reg)
            S_IDLE:       cmd.pos_write = start && (operation == OP_WRITE);
            S_CLEAR:      cmd.clear_step = 1'b1;
            S_LOAD:       cmd.pos_read = 1'b1;
            S_EDGE:       cmd.edge_calc = 1'b1;
            S_CROSS:      cmd.cross_calc = 1'b1;
            S_CROSS2:     cmd.cross_sub = 1'b1;
            S_NORM_START: cmd.norm_start = 1'b1;
            S_ACC_RD:     cmd.sum_read = 1'b1;
            S_ACC_WR:     cmd.sum_write = 1'b1;
            S_READ_RD:
            begin
                cmd.sum_read = 1'b1;
                cmd.corner_sel = 2'd0;
            end
            S_READ_WAIT:  cmd.read_norm_start = 1'b1;
            S_READ_DONE:  cmd.emit = 1'b1;
            default:      ;
        endcase
        cmd.result_from_read = (state_reg == S_READ_RD) || (state_reg == S_READ_WAIT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            quad_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            quad_reg <= quad_next;
            cnt_reg <= cnt_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    `include "assert_macros.svh"
    `ASSERT_IMPL(a_emit_idle, clk, rst_n, cmd.emit |=> !busy, "emit not final")
    `ASSERT_NEVER(a_rd_wr, clk, rst_n, cmd.sum_read && cmd.sum_write, "sum port clash")
    `ASSERT_IMPL(a_acc_seq, clk, rst_n, (state_reg == S_ACC_RD) |=> (state_reg == S_ACC_WAIT), "acc order")

endmodule

FILE: design/vna_dpath.sv
// Datapath: position and sum memories, edge and cross product, scaler unit.
// Depends on vna_pkg and vna_unit.
module vna_dpath #(
    parameter int MAX_VERTICES = 1024,
    parameter int SUM_BITS     = 20
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  vna_pkg::item_in_t  item_in,
    input  logic               take,
    input  vna_pkg::cmd_t      cmd,
    output vna_pkg::status_t   status,
    output logic               strobe,
    output vna_pkg::item_out_t item_out
);
    import vna_pkg::*;

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

    logic signed [CRD_BITS-1:0] px_mem [MAX_VERTICES];
    logic signed [CRD_BITS-1:0] py_mem [MAX_VERTICES];
    logic signed [CRD_BITS-1:0] pz_mem [MAX_VERTICES];
    logic signed [SUM_BITS-1:0] sx_mem [MAX_VERTICES];
    logic signed [SUM_BITS-1:0] sy_mem [MAX_VERTICES];
    logic signed [SUM_BITS-1:0] sz_mem [MAX_VERTICES];

    item_in_t                   item_reg;
    logic [AW-1:0]              addr;
    logic [AW-1:0]              clr_reg;
    logic signed [CRD_BITS-1:0] prd [3];
    logic signed [CRD_BITS-1:0] cp_reg [4][3];
    logic                       ld_v_reg;
    logic [1:0]                 ld_k_reg;
    logic signed [SUM_BITS-1:0] srd [3];
    logic signed [CRD_BITS+1:0] e0_reg [3], e1_reg [3];
    logic signed [63:0]         m_reg [6];
    logic signed [63:0]         n_reg [3];
    logic                       readmode_reg;
    logic                       ustart;
    logic signed [63:0]         uv [3];
    logic                       udone, uzero;
    logic signed [NRM_BITS-1:0] ux, uy, uz;
    logic signed [SUM_BITS:0]   tsum [3];
    logic signed [SUM_BITS-1:0] sat [3];
    logic signed [NRM_BITS-1:0] u_reg [3];

    always_ff @(posedge clk)
    begin
        if (take) item_reg <= item_in;
    end

    always_comb
    begin
        unique case (cmd.corner_sel)
            2'd0: addr = AW'(item_reg.index_a);
            2'd1: addr = AW'(item_reg.index_b);
            2'd2: addr = AW'(item_reg.index_c);
            2'd3: addr = AW'(item_reg.index_d);
            default: addr = AW'(item_reg.index_a);
        endcase
    end

    // Position memories: write from the input directly, read registered.
    always_ff @(posedge clk)
    begin
        if (cmd.pos_write)
        begin
            px_mem[AW'(item_in.index_a)] <= item_in.pos_x;
            py_mem[AW'(item_in.index_a)] <= item_in.pos_y;
            pz_mem[AW'(item_in.index_a)] <= item_in.pos_z;
        end
        prd[0] <= px_mem[addr];
        prd[1] <= py_mem[addr];
        prd[2] <= pz_mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ld_v_reg <= 1'b0;
            ld_k_reg <= '0;
        end
        else
        begin
            ld_v_reg <= cmd.pos_read;
            ld_k_reg <= cmd.corner_sel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_v_reg)
        begin
            for (int i = 0; i < 3; i++) cp_reg[ld_k_reg][i] <= prd[i];
        end
        if (cmd.edge_calc)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (readmode_reg)
                begin
                    e0_reg[i] <= '0;
                    e1_reg[i] <= '0;
                end
                else if (item_reg.operation == OP_QUAD)
                begin
                    e0_reg[i] <= (CRD_BITS+2)'(cp_reg[1][i]) - cp_reg[0][i]
                                 + cp_reg[2][i] - cp_reg[3][i];
                    e1_reg[i] <= (CRD_BITS+2)'(cp_reg[3][i]) - cp_reg[0][i]
                                 + cp_reg[2][i] - cp_reg[1][i];
                end
                else
                begin
                    e0_reg[i] <= (CRD_BITS+2)'(cp_reg[1][i]) - cp_reg[0][i];
                    e1_reg[i] <= (CRD_BITS+2)'(cp_reg[2][i]) - cp_reg[0][i];
                end
            end
        end
        if (cmd.cross_calc)
        begin
            m_reg[0] <= 64'(e0_reg[1] * e1_reg[2]);
            m_reg[1] <= 64'(e0_reg[2] * e1_reg[1]);
            m_reg[2] <= 64'(e0_reg[2] * e1_reg[0]);
            m_reg[3] <= 64'(e0_reg[0] * e1_reg[2]);
            m_reg[4] <= 64'(e0_reg[0] * e1_reg[1]);
            m_reg[5] <= 64'(e0_reg[1] * e1_reg[0]);
        end
        if (cmd.cross_sub)
        begin
            n_reg[0] <= m_reg[0] - m_reg[1];
            n_reg[1] <= m_reg[2] - m_reg[3];
            n_reg[2] <= m_reg[4] - m_reg[5];
        end
        if (cmd.sum_read) readmode_reg <= cmd.result_from_read;
        else if (cmd.pos_read) readmode_reg <= 1'b0;
    end

    // Sum memories; the clear sweep runs one entry a cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
        begin
            sx_mem[clr_reg] <= '0;
            sy_mem[clr_reg] <= '0;
            sz_mem[clr_reg] <= '0;
        end
        else if (cmd.sum_write)
        begin
            sx_mem[addr] <= sat[0];
            sy_mem[addr] <= sat[1];
            sz_mem[addr] <= sat[2];
        end
        srd[0] <= sx_mem[addr];
        srd[1] <= sy_mem[addr];
        srd[2] <= sz_mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) clr_reg <= '0;
        else if (cmd.clear_step) clr_reg <= (32'(clr_reg) == MAX_VERTICES - 1) ? '0 : clr_reg + 1'b1;
    end

    assign status.clear_done = cmd.clear_step && (32'(clr_reg) == MAX_VERTICES - 1);

    always_comb
    begin
        tsum[0] = (SUM_BITS+1)'(srd[0]) + (SUM_BITS+1)'(u_reg[0]);
        tsum[1] = (SUM_BITS+1)'(srd[1]) + (SUM_BITS+1)'(u_reg[1]);
        tsum[2] = (SUM_BITS+1)'(srd[2]) + (SUM_BITS+1)'(u_reg[2]);
        for (int i = 0; i < 3; i++)
        begin
            if (tsum[i][SUM_BITS] != tsum[i][SUM_BITS-1])
                sat[i] = tsum[i][SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                           : {1'b0, {(SUM_BITS-1){1'b1}}};
            else
                sat[i] = tsum[i][SUM_BITS-1:0];
        end
        ustart = cmd.norm_start || cmd.read_norm_start;
        for (int i = 0; i < 3; i++)
            uv[i] = cmd.read_norm_start ? 64'(srd[i]) : n_reg[i];
    end

    vna_unit u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ustart),
        .vx    (uv[0]),
        .vy    (uv[1]),
        .vz    (uv[2]),
        .done  (udone),
        .zero  (uzero),
        .ux    (ux),
        .uy    (uy),
        .uz    (uz)
    );

    always_ff @(posedge clk)
    begin
        if (udone)
        begin
            u_reg[0] <= ux;
            u_reg[1] <= uy;
            u_reg[2] <= uz;
        end
    end

    assign status.norm_done = udone;
    assign status.norm_zero = uzero;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) strobe <= 1'b0;
        else strobe <= cmd.emit;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            item_out.vertex_index <= IDX_BITS'(AW'(item_reg.index_a));
            item_out.normal_x <= u_reg[0];
            item_out.normal_y <= u_reg[1];
            item_out.normal_z <= u_reg[2];
            item_out.is_zero <= (u_reg[0] == '0) && (u_reg[1] == '0) && (u_reg[2] == '0);
        end
    end

    `include "assert_macros.svh"
    `ASSERT_NEVER(a_clr_wr, clk, rst_n, cmd.clear_step && cmd.sum_write, "clear during write")
    `ASSERT_IMPL(a_strobe, clk, rst_n, cmd.emit |=> strobe, "strobe missed")
    `ASSERT_NEVER(a_two_start, clk, rst_n, cmd.norm_start && cmd.read_norm_start, "two starts")

endmodule

FILE: tb/vertex_normal_accumulator_core_test.sv
// Testbench for vertex_normal_accumulator_core: directed and random face, write,
// read and clear items, with every read normal checked against a built-in predictor.
// Depends on vna_pkg and the RTL of vertex_normal_accumulator_core.
`timescale 1ns / 1ps

module vertex_normal_accumulator_core_test;
    import vna_pkg::*;

    localparam int  NUM_VERTS   = 1024;
    localparam int  SUM_MAX     = 524287;
    localparam int  SUM_MIN     = -524288;
    localparam int  CYCLE_LIMIT = 1500000;
    localparam int  TAIL_CYCLES = 200;

    // Mirrors the position and sum stores and queues the normals that reads produce.
    class normal_scoreboard;
        int        pos_x[NUM_VERTS];
        int        pos_y[NUM_VERTS];
        int        pos_z[NUM_VERTS];
        int        sum_x[NUM_VERTS];
        int        sum_y[NUM_VERTS];
        int        sum_z[NUM_VERTS];
        item_out_t pending_normals[$];
        int        errors;

        function new();
            for (int i = 0; i < NUM_VERTS; i++)
            begin
                pos_x[i] = 0; pos_y[i] = 0; pos_z[i] = 0;
                sum_x[i] = 0; sum_y[i] = 0; sum_z[i] = 0;
            end
            errors = 0;
        endfunction

        function longint unsigned isqrt(longint unsigned q);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > q)
                b >>= 2;
            while (b != 0)
            begin
                if (q >= r + b)
                begin
                    q -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        // Scales v to Q1.14 unit length; returns 0 for the zero vector.
        function bit scale_to_unit(input longint v[3], output int u[3]);
            longint unsigned mag[3];
            longint unsigned top;
            longint unsigned q;
            longint unsigned nrm;
            longint unsigned c;
            int len;
            top = 0;
            q = 0;
            len = 0;
            for (int i = 0; i < 3; i++)
            begin
                mag[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
                if (mag[i] > top)
                    top = mag[i];
                u[i] = 0;
            end
            if (top == 0)
                return 0;
            while (len < 64 && (top >> len) != 0)
                len++;
            for (int i = 0; i < 3; i++)
            begin
                if (len > 30)
                    mag[i] >>= (len - 30);
                else
                    mag[i] <<= (30 - len);
                q += mag[i] * mag[i];
            end
            nrm = isqrt(q);
            for (int i = 0; i < 3; i++)
            begin
                c = (mag[i] * UNIT + nrm / 2) / nrm;
                if (c > UNIT)
                    c = UNIT;
                u[i] = (v[i] < 0) ? -int'(c) : int'(c);
            end
            return 1;
        endfunction

        function int sat_add(int s, int d);
            int t;
            t = s + d;
            if (t > SUM_MAX)
                t = SUM_MAX;
            if (t < SUM_MIN)
                t = SUM_MIN;
            return t;
        endfunction

        function void add_face(int corner[4], int count);
            longint e0[3];
            longint e1[3];
            longint n[3];
            longint p[4][3];
            int u[3];
            for (int k = 0; k < count; k++)
            begin
                p[k][0] = pos_x[corner[k]];
                p[k][1] = pos_y[corner[k]];
                p[k][2] = pos_z[corner[k]];
            end
            for (int k = 0; k < 3; k++)
            begin
                if (count == 4)
                begin
                    e0[k] = (p[1][k] - p[0][k]) + (p[2][k] - p[3][k]);
                    e1[k] = (p[3][k] - p[0][k]) + (p[2][k] - p[1][k]);
                end
                else
                begin
                    e0[k] = p[1][k] - p[0][k];
                    e1[k] = p[2][k] - p[0][k];
                end
            end
            n[0] = e0[1] * e1[2] - e0[2] * e1[1];
            n[1] = e0[2] * e1[0] - e0[0] * e1[2];
            n[2] = e0[0] * e1[1] - e0[1] * e1[0];
            if (!scale_to_unit(n, u))
                return;
            for (int k = 0; k < count; k++)
            begin
                sum_x[corner[k]] = sat_add(sum_x[corner[k]], u[0]);
                sum_y[corner[k]] = sat_add(sum_y[corner[k]], u[1]);
                sum_z[corner[k]] = sat_add(sum_z[corner[k]], u[2]);
            end
        endfunction

        function void note_item(item_in_t it);
            int corner[4];
            longint s[3];
            int u[3];
            item_out_t r;
            corner[0] = it.index_a;
            corner[1] = it.index_b;
            corner[2] = it.index_c;
            corner[3] = it.index_d;
            case (it.operation)
                OP_WRITE:
                begin
                    pos_x[corner[0]] = it.pos_x;
                    pos_y[corner[0]] = it.pos_y;
                    pos_z[corner[0]] = it.pos_z;
                end
                OP_TRI:
                    add_face(corner, 3);
                OP_QUAD:
                    add_face(corner, 4);
                OP_CLEAR:
                    for (int i = 0; i < NUM_VERTS; i++)
                    begin
                        sum_x[i] = 0; sum_y[i] = 0; sum_z[i] = 0;
                    end
                OP_READ:
                begin
                    s[0] = sum_x[corner[0]];
                    s[1] = sum_y[corner[0]];
                    s[2] = sum_z[corner[0]];
                    r.is_zero      = !scale_to_unit(s, u);
                    r.vertex_index = it.index_a;
                    r.normal_x     = 16'(u[0]);
                    r.normal_y     = 16'(u[1]);
                    r.normal_z     = 16'(u[2]);
                    pending_normals.push_back(r);
                end
                default:
                    ;
            endcase
        endfunction

        task report_mismatch(string what, longint got, longint want);
            $display("mismatch at %0t: %s got %0d, expected %0d", $time, what, got, want);
            errors++;
        endtask

        task check_normal(item_out_t got);
            item_out_t want;
            if (pending_normals.size() == 0)
            begin
                report_mismatch("unexpected normal for vertex", got.vertex_index, -1);
                return;
            end
            want = pending_normals.pop_front();
            if (got.vertex_index !== want.vertex_index)
                report_mismatch("vertex_index", got.vertex_index, want.vertex_index);
            if (got.normal_x !== want.normal_x)
                report_mismatch("normal_x", got.normal_x, want.normal_x);
            if (got.normal_y !== want.normal_y)
                report_mismatch("normal_y", got.normal_y, want.normal_y);
            if (got.normal_z !== want.normal_z)
                report_mismatch("normal_z", got.normal_z, want.normal_z);
            if (got.is_zero !== want.is_zero)
                report_mismatch("is_zero", got.is_zero, want.is_zero);
        endtask
    endclass

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    item_in_t  item_in;
    logic      strobe;
    item_out_t item_out;

    normal_scoreboard sb;
    int        cycles;
    int        sender_idle_pct;
    int        written[$];
    bit        is_written[NUM_VERTS];

    vertex_normal_accumulator_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .item_in  (item_in),
        .strobe   (strobe),
        .item_out (item_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
        if (rst_n && start && !busy)
            sb.note_item(item_in);
        if (rst_n && strobe)
            sb.check_normal(item_out);
    end

    function automatic item_in_t make_item(op_t op, int a, int b, int c, int d,
                                           int x, int y, int z);
        item_in_t it;
        it.operation = op;
        it.index_a   = a;
        it.index_b   = b;
        it.index_c   = c;
        it.index_d   = d;
        it.pos_x     = x;
        it.pos_y     = y;
        it.pos_z     = z;
        return it;
    endfunction

    function automatic int rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 16777215) - 8388608;
            1: return $urandom_range(0, 65535) - 32768;
            2: return $urandom_range(0, 1) ? 8388607 : -8388608;
            default: return $urandom_range(0, 511) - 256;
        endcase
    endfunction

    function automatic int pick_written();
        return written[$urandom_range(0, written.size() - 1)];
    endfunction

    task automatic send_item(item_in_t it);
        if (it.operation == OP_WRITE && !is_written[it.index_a])
        begin
            is_written[it.index_a] = 1'b1;
            written.push_back(it.index_a);
        end
        @(negedge clk);
        start   <= 1'b1;
        item_in <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if ($urandom_range(0, 99) < sender_idle_pct)
        begin
            @(negedge clk);
            start   <= 1'b0;
            item_in <= item_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
            repeat ($urandom_range(0, 6))
                @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending_normals.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random_face(bit quad);
        int a;
        int b;
        int c;
        int d;
        a = pick_written();
        b = pick_written();
        c = pick_written();
        d = pick_written();
        send_item(make_item(quad ? OP_QUAD : OP_TRI, a, b, c, d,
                            $urandom, $urandom, $urandom));
    endtask

    // One random step, sometimes a short sequence such as a burst of one face.
    task automatic send_random_step();
        int sel;
        int a;
        item_in_t face;
        sel = $urandom_range(0, 99);
        if (sel < 22)
        begin
            if (written.size() < 48 && $urandom_range(0, 3) != 0)
                a = $urandom_range(0, NUM_VERTS - 1);
            else
                a = pick_written();
            send_item(make_item(OP_WRITE, a, $urandom, $urandom, $urandom,
                                rand_coord(), rand_coord(), rand_coord()));
        end
        else if (sel < 45)
            send_random_face(1'b0);
        else if (sel < 60)
            send_random_face(1'b1);
        else if (sel < 63)
        begin
            // Repeated identical faces drive the corner sums into saturation.
            face = make_item($urandom_range(0, 1) ? OP_QUAD : OP_TRI, pick_written(),
                             pick_written(), pick_written(), pick_written(), 0, 0, 0);
            repeat ($urandom_range(8, 40))
                send_item(face);
            send_item(make_item(OP_READ, face.index_a, $urandom, $urandom, $urandom,
                                $urandom, $urandom, $urandom));
        end
        else if (sel < 64)
            send_item(make_item(OP_CLEAR, $urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom, $urandom));
        else if (sel < 67)
            send_item(make_item(op_t'($urandom_range(5, 7)), $urandom, $urandom,
                                $urandom, $urandom, $urandom, $urandom, $urandom));
        else
        begin
            a = ($urandom_range(0, 4) == 0) ? $urandom_range(0, NUM_VERTS - 1)
                                            : pick_written();
            send_item(make_item(OP_READ, a, $urandom, $urandom, $urandom,
                                $urandom, $urandom, $urandom));
        end
    endtask

    initial
    begin
        int guard;
        item_out_t lost;
        sb = new();
        cycles = 0;
        sender_idle_pct = 0;
        rst_n   = 1'b0;
        start   = 1'b0;
        item_in = '0;
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extreme positions, both face kinds and the special cases.
        send_item(make_item(OP_READ, 1023, 0, 0, 0, 0, 0, 0));
        send_item(make_item(OP_WRITE, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(OP_WRITE, 1, 0, 0, 0, 8388607, 0, 0));
        send_item(make_item(OP_WRITE, 2, 0, 0, 0, 0, 8388607, 0));
        send_item(make_item(OP_WRITE, 1023, 1023, 1023, 1023,
                            -8388608, -8388608, -8388608));
        send_item(make_item(OP_TRI, 0, 1, 2, 0, 0, 0, 0));
        send_item(make_item(OP_READ, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(OP_TRI, 0, 0, 1, 0, 0, 0, 0));
        send_item(make_item(OP_READ, 1023, 0, 0, 0, 0, 0, 0));
        send_item(make_item(OP_QUAD, 0, 1, 1023, 2, 0, 0, 0));
        send_item(make_item(OP_QUAD, 1023, 2, 1, 1023, 0, 0, 0));
        send_item(make_item(OP_TRI, 1023, 1, 2, 1023, 0, 0, 0));
        send_item(make_item(OP_READ, 1023, 0, 0, 0, 0, 0, 0));
        send_item(make_item(OP_READ, 2, 0, 0, 0, 0, 0, 0));
        send_item(make_item(op_t'(3'd5), 1, 2, 3, 4, 5, 6, 7));
        send_item(make_item(op_t'(3'd6), 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(op_t'(3'd7), 1023, 1023, 1023, 1023, -1, -1, -1));
        send_item(make_item(OP_READ, 1, 0, 0, 0, 0, 0, 0));
        send_item(make_item(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(OP_READ, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(OP_READ, 1023, 0, 0, 0, 0, 0, 0));
        wait_drained();

        // A step sends about 1.7 items on average because of the saturation bursts.
        for (int phase = 0; phase < 3; phase++)
        begin
            sender_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 46 : 0;
            for (int n = 0; n < 240; n++)
                send_random_step();
        end

        @(negedge clk);
        start <= 1'b0;
        guard = 0;
        while (sb.pending_normals.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (TAIL_CYCLES)
            @(posedge clk);
        while (sb.pending_normals.size() != 0)
        begin
            lost = sb.pending_normals.pop_front();
            sb.report_mismatch("normal never arrived for vertex", -1, lost.vertex_index);
        end
        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+design
design/vna_pkg.sv
design/vna_unit.sv
design/vna_ctrl.sv
design/vna_dpath.sv
design/vertex_normal_accumulator_core.sv
tb/vertex_normal_accumulator_core_test.sv
